[hdl/phase_angle_gate_sequencer_assert.svh]
// Assertion macros shared by the gate sequencer modules.
`ifndef PHASE_ANGLE_GATE_SEQUENCER_ASSERT_SVH
`define PHASE_ANGLE_GATE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define PAGS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define PAGS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PAGS_ASSERT_SAME(lbl, ante, cons)
`define PAGS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/pags_pkg.sv]
// Types, codes and reset constants of the phase-angle gate sequencer.
package pags_pkg;

    localparam int CNT_BITS_DEFAULT = 16;
    localparam int DUTY_BITS        = 10;
    localparam int RELOAD_BITS      = 16;
    localparam int STEP_BITS        = 6;
    localparam int PROD_BITS        = DUTY_BITS + STEP_BITS;
    localparam int ACT_BITS         = 2;
    localparam int SEQ_BITS         = 3;
    localparam int APB_ADDR_BITS    = 4;
    localparam int APB_DATA_BITS    = 32;

    // Item kinds
    localparam logic [ACT_BITS-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_ZC   = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_DUTY = 2'd2;

    // Firing sequence steps, one per counter wrap
    localparam logic [SEQ_BITS-1:0] SEQ_IDLE   = 3'd0;
    localparam logic [SEQ_BITS-1:0] SEQ_ARMED  = 3'd1;
    localparam logic [SEQ_BITS-1:0] SEQ_PULSE1 = 3'd2;
    localparam logic [SEQ_BITS-1:0] SEQ_GAP    = 3'd3;
    localparam logic [SEQ_BITS-1:0] SEQ_PULSE2 = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_PULSE_RELOAD  = 2'd0;
    localparam logic [1:0] REG_SECOND_RELOAD = 2'd1;
    localparam logic [1:0] REG_OFF_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_DUTY_STEP     = 2'd3;

    localparam logic [RELOAD_BITS-1:0] PULSE_RELOAD_RST  = 16'd65422;
    localparam logic [RELOAD_BITS-1:0] SECOND_RELOAD_RST = 16'd62717;
    localparam logic [DUTY_BITS-1:0]   OFF_THRESHOLD_RST = 10'd975;
    localparam logic [STEP_BITS-1:0]   DUTY_STEP_RST     = 6'd2;

    typedef struct packed {
        logic [RELOAD_BITS-1:0] pulse_reload;
        logic [RELOAD_BITS-1:0] second_half_reload;
        logic [DUTY_BITS-1:0]   off_threshold;
        logic [STEP_BITS-1:0]   duty_step;
    } cfg_t;

    typedef struct packed {
        logic gate_out;
        logic phase_out;
        logic sample_request;
    } res_t;

endpackage

[hdl/pags_cfg.sv]
// APB register file holding the sequencer configuration.
module pags_cfg import pags_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_reload       <= PULSE_RELOAD_RST;
            cfg_reg.second_half_reload <= SECOND_RELOAD_RST;
            cfg_reg.off_threshold      <= OFF_THRESHOLD_RST;
            cfg_reg.duty_step          <= DUTY_STEP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PULSE_RELOAD:  cfg_reg.pulse_reload       <= pwdata[RELOAD_BITS-1:0];
                REG_SECOND_RELOAD: cfg_reg.second_half_reload <= pwdata[RELOAD_BITS-1:0];
                REG_OFF_THRESHOLD: cfg_reg.off_threshold      <= pwdata[DUTY_BITS-1:0];
                REG_DUTY_STEP:     cfg_reg.duty_step          <= pwdata[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PULSE_RELOAD:  prdata = APB_DATA_BITS'(cfg_reg.pulse_reload);
            REG_SECOND_RELOAD: prdata = APB_DATA_BITS'(cfg_reg.second_half_reload);
            REG_OFF_THRESHOLD: prdata = APB_DATA_BITS'(cfg_reg.off_threshold);
            REG_DUTY_STEP:     prdata = APB_DATA_BITS'(cfg_reg.duty_step);
            default:           prdata = '0;
        endcase
    end

endmodule

[hdl/pags_core.sv]
// Counter, firing sequence and duty-to-delay state, updated once per accepted item.
`include "phase_angle_gate_sequencer_assert.svh"
module pags_core import pags_pkg::*; #(
    parameter int COUNTER_BITS = CNT_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [ACT_BITS-1:0]  in_action,
    input  logic                 in_level,
    input  logic [DUTY_BITS-1:0] in_duty,
    input  cfg_t                 cfg,
    output res_t                 result
);

    localparam int EXT_BITS = (COUNTER_BITS > PROD_BITS) ? COUNTER_BITS : PROD_BITS;

    logic [COUNTER_BITS-1:0] cnt_reg,   cnt_next;
    logic [COUNTER_BITS-1:0] delay_reg, delay_next;
    logic [SEQ_BITS-1:0]     step_reg,  step_next;
    logic [DUTY_BITS-1:0]    duty_reg,  duty_next;
    logic                    gate_reg,  gate_next;
    logic                    phase_reg, phase_next;
    logic                    req;
    logic [COUNTER_BITS-1:0] cnt_inc;
    logic                    fire_en;
    logic [PROD_BITS-1:0]    prod;
    logic [EXT_BITS-1:0]     prod_ext;

    assign cnt_inc  = cnt_reg + COUNTER_BITS'(1);
    assign fire_en  = duty_reg < cfg.off_threshold;
    assign prod     = PROD_BITS'(in_duty) * PROD_BITS'(cfg.duty_step);
    assign prod_ext = EXT_BITS'(prod);

    always_comb begin
        cnt_next   = cnt_reg;
        delay_next = delay_reg;
        step_next  = step_reg;
        duty_next  = duty_reg;
        gate_next  = gate_reg;
        phase_next = phase_reg;
        req        = 1'b0;
        unique case (in_action)
            ACT_TICK: begin
                cnt_next = cnt_inc;
                if (cnt_inc == '0) begin
                    if (!fire_en) begin
                        gate_next = 1'b1;
                    end else begin
                        unique case (step_reg)
                            SEQ_ARMED: begin
                                cnt_next  = COUNTER_BITS'(cfg.pulse_reload);
                                gate_next = 1'b0;
                                step_next = SEQ_PULSE1;
                            end
                            SEQ_PULSE1: begin
                                cnt_next  = COUNTER_BITS'(cfg.second_half_reload);
                                gate_next = 1'b1;
                                step_next = SEQ_GAP;
                            end
                            SEQ_GAP: begin
                                cnt_next  = COUNTER_BITS'(cfg.pulse_reload);
                                gate_next = 1'b0;
                                step_next = SEQ_PULSE2;
                            end
                            SEQ_PULSE2: begin
                                cnt_next  = '0;
                                gate_next = 1'b1;
                                step_next = SEQ_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ACT_ZC: begin
                // rising edge arms the sequence from the duty delay
                if (in_level) begin
                    cnt_next  = delay_reg;
                    gate_next = 1'b1;
                    step_next = SEQ_ARMED;
                end
                phase_next = in_level;
                req        = 1'b1;
            end
            ACT_DUTY: begin
                duty_next  = in_duty;
                // all-ones minus the product, modulo the counter width
                delay_next = ~prod_ext[COUNTER_BITS-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            delay_reg <= '0;
            step_reg  <= SEQ_IDLE;
            duty_reg  <= '0;
            gate_reg  <= 1'b1;
            phase_reg <= 1'b0;
        end else if (accept) begin
            cnt_reg   <= cnt_next;
            delay_reg <= delay_next;
            step_reg  <= step_next;
            duty_reg  <= duty_next;
            gate_reg  <= gate_next;
            phase_reg <= phase_next;
        end
    end

    assign result.gate_out       = gate_next;
    assign result.phase_out      = phase_next;
    assign result.sample_request = req;

    `PAGS_ASSERT_SAME(a_step_range, 1'b1, step_reg <= SEQ_PULSE2)
    `PAGS_ASSERT_SAME(a_idle_gate_high, step_reg == SEQ_IDLE, gate_reg)
    `PAGS_ASSERT_NEXT(a_zc_arms, accept && in_action == ACT_ZC && in_level, cnt_reg == $past(delay_reg) && step_reg == SEQ_ARMED && gate_reg)

endmodule

[hdl/pags_out_buf.sv]
// Two-entry result buffer: output register plus skid stage.
`include "phase_angle_gate_sequencer_assert.svh"
module pags_out_buf import pags_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    res_t main_reg, skid_reg;
    logic main_valid_reg, skid_valid_reg;
    logic push, pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = main_valid_reg && m_ready;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (skid_valid_reg && pop) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (push && (!main_valid_reg || pop)) begin
                main_valid_reg <= 1'b1;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end else if (pop) begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (skid_valid_reg && pop) begin
            main_reg <= skid_reg;
        end else if (push && (!main_valid_reg || pop)) begin
            main_reg <= in_data;
        end else if (push) begin
            skid_reg <= in_data;
        end
    end

    `PAGS_ASSERT_SAME(a_skid_behind_main, skid_valid_reg, main_valid_reg)
    `PAGS_ASSERT_SAME(a_stall_has_result, !in_ready, m_valid)
    `PAGS_ASSERT_NEXT(a_push_on_stall_skids, push && main_valid_reg && !m_ready, skid_valid_reg)

endmodule

[hdl/phase_angle_gate_sequencer.sv]
// Phase-angle gate sequencer top level: APB registers, sequencer core and result buffer.
// Takes one item (timer tick, zero-cross level change or duty write) in every clock cycle
// while s_ready is high and returns one registered result item per input. All state is
// updated by a single pass of logic at the input handshake; results go to a two-entry
// output buffer, so s_ready drops only when both entries are full, and a stalled
// consumer costs no throughput until then. The tick counter is COUNTER_BITS wide; the
// delay after a rising zero-cross is (duty * duty_step mod 2^COUNTER_BITS) + 1 ticks.
// Write configuration only while no items are in flight.
module phase_angle_gate_sequencer import pags_pkg::*; #(
    parameter int COUNTER_BITS = CNT_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ACT_BITS-1:0]      s_action,
    input  logic                     s_zero_cross_level,
    input  logic [DUTY_BITS-1:0]     s_duty_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_gate_out,
    output logic                     m_phase_out,
    output logic                     m_sample_request,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t cfg;
    res_t core_res;
    res_t out_res;
    logic accept;

    assign accept = s_valid && s_ready;

    pags_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pags_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_action (s_action),
        .in_level  (s_zero_cross_level),
        .in_duty   (s_duty_value),
        .cfg       (cfg),
        .result    (core_res)
    );

    pags_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (core_res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (out_res)
    );

    assign m_gate_out       = out_res.gate_out;
    assign m_phase_out      = out_res.phase_out;
    assign m_sample_request = out_res.sample_request;

endmodule
